// File: hw/rtl/smt_pkg.sv
package smt_pkg;

  localparam int MaxLen = 32;
  localparam int IdxW = $clog2(MaxLen);
  localparam int CntW = $clog2(MaxLen + 1);
  localparam logic [16:0] Log2eQ16 = 17'd94548;
  localparam logic [21:0] SumLimit = 22'd4194303;

  typedef struct packed {
    logic signed [15:0] score;
    logic               last_element;
  } in_word_t;

  typedef struct packed {
    logic [15:0] probability;
    logic [5:0]  element_index;
    logic        last_result;
    logic        overflow;
  } out_word_t;

  // commands from controller to datapath
  typedef struct packed {
    logic           load;       // store incoming score, update max
    logic           clear;      // restart the vector
    logic           exp_start;  // start exp pipeline for entry idx
    logic           div_start;  // start divide for entry idx
    logic [IdxW-1:0] idx;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic            exp_done;
    logic            div_done;
    logic [CntW-1:0] count;
  } dp_stat_t;

  // 2^(-k/16) in unsigned Q1.16
  function automatic logic [16:0] pow2_neg(input logic [4:0] k);
    logic [16:0] v;
    begin
      unique case (k)
        5'd0:  v = 17'd65536;
        5'd1:  v = 17'd62758;
        5'd2:  v = 17'd60097;
        5'd3:  v = 17'd57549;
        5'd4:  v = 17'd55109;
        5'd5:  v = 17'd52773;
        5'd6:  v = 17'd50535;
        5'd7:  v = 17'd48393;
        5'd8:  v = 17'd46341;
        5'd9:  v = 17'd44376;
        5'd10: v = 17'd42495;
        5'd11: v = 17'd40693;
        5'd12: v = 17'd38968;
        5'd13: v = 17'd37316;
        5'd14: v = 17'd35734;
        5'd15: v = 17'd34219;
        5'd16: v = 17'd32768;
        default: v = 17'd0;
      endcase
      return v;
    end
  endfunction

endpackage

// File: hw/rtl/smt_datapath.sv
module smt_datapath (
  input  logic                clk,
  input  logic                rst,
  input  smt_pkg::dp_cmd_t    cmd,
  input  logic signed [15:0]  in_score,
  input  logic [15:0]         inv_temperature,
  output smt_pkg::dp_stat_t   stat,
  output logic [15:0]         quotient
);
  import smt_pkg::*;

  logic [15:0]        score_mem [MaxLen];
  logic [16:0]        exp_mem [MaxLen];
  logic signed [15:0] running_max;
  logic [CntW-1:0]    count;
  logic [21:0]        exp_sum;

  // score buffer write and max tracking
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      running_max <= 16'sh8000;
      count <= '0;
    end else if (cmd.load) begin
      score_mem[count[IdxW-1:0]] <= in_score;
      if (in_score > running_max) running_max <= in_score;
      count <= count + 1'b1;
    end
  end

  // exp pipeline: read, diff*invt, *log2e, table interpolate, shift
  logic [15:0]     s_rd;
  logic [IdxW-1:0] i1, i2, i3, i4;
  logic            v1, v2, v3, v4;
  logic [31:0]     d2;
  logic [32:0]     y3;
  logic [16:0]     e4;

  always_ff @(posedge clk) begin
    s_rd <= score_mem[cmd.idx];
    i1 <= cmd.idx;
  end

  logic [16:0] diff;
  logic [48:0] yfull;
  logic [15:0] frac;
  logic [3:0]  ti;
  logic [11:0] tr;
  logic [16:0] thi, tlo, tv;
  logic [28:0] tprod;
  logic [32:0] ymsb;
  always_comb begin
    diff = 17'($signed({running_max[15], running_max}) - $signed({s_rd[15], s_rd}));
    yfull = 49'(d2) * 49'(Log2eQ16) + 49'd32768;
    frac = y3[15:0];
    ti = frac[15:12];
    tr = frac[11:0];
    thi = pow2_neg({1'b0, ti});
    tlo = pow2_neg(5'({1'b0, ti} + 5'd1));
    tprod = 29'(thi - tlo) * 29'(tr) + 29'd2048;
    tv = thi - 17'(tprod >> 12);
    ymsb = y3 >> 16;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
    end else begin
      v1 <= cmd.exp_start; v2 <= v1; v3 <= v2; v4 <= v3;
    end
    d2 <= 32'(diff) * 32'(inv_temperature);
    i2 <= i1;
    y3 <= yfull[48:16];
    i3 <= i2;
    e4 <= (ymsb >= 33'd17) ? 17'd0 : (tv >> ymsb[4:0]);
    i4 <= i3;
  end

  // exp store and saturating sum
  logic [22:0] sum_t;
  assign sum_t = 23'(exp_sum) + 23'(e4);
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) exp_sum <= '0;
    else if (v4) exp_sum <= (sum_t > 23'(SumLimit)) ? SumLimit : sum_t[21:0];
    if (v4) exp_mem[i4] <= e4;
  end

  // restoring divider, one quotient bit per cycle
  logic [16:0] e_rd;
  logic        rd_v;
  logic [38:0] num;
  logic [22:0] rem;
  logic [33:0] q;
  logic [5:0]  bitc;
  logic        busy, div_done;
  logic [23:0] rem_sh;
  always_ff @(posedge clk) begin
    e_rd <= exp_mem[cmd.idx];
  end
  assign rem_sh = {rem, num[38]};
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v <= 1'b0; busy <= 1'b0; div_done <= 1'b0;
    end else begin
      rd_v <= cmd.div_start;
      div_done <= 1'b0;
      if (rd_v) begin
        num <= 39'(({22'd0, e_rd, 16'd0}) + 55'(exp_sum >> 1));
        rem <= '0; q <= '0; bitc <= 6'd39; busy <= 1'b1;
      end else if (busy) begin
        num <= num << 1;
        if (rem_sh >= 24'(exp_sum)) begin
          rem <= 23'(rem_sh - 24'(exp_sum)); q <= {q[32:0], 1'b1};
        end else begin
          rem <= rem_sh[22:0]; q <= {q[32:0], 1'b0};
        end
        bitc <= bitc - 1'b1;
        if (bitc == 6'd1) begin
          busy <= 1'b0; div_done <= 1'b1;
        end
      end
    end
  end
  assign quotient = (exp_sum == '0) ? 16'd0 : ((q > 34'd65535) ? 16'hFFFF : q[15:0]);

  // sweep done once the last element leaves an otherwise empty pipeline
  assign stat.exp_done = v4 && !(v1 || v2 || v3);
  assign stat.div_done = div_done;
  assign stat.count = count;

endmodule

// File: hw/rtl/smt_ctrl.sv
module smt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  smt_pkg::in_word_t   in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output smt_pkg::out_word_t  out_word,
  output smt_pkg::dp_cmd_t    cmd,
  input  smt_pkg::dp_stat_t   stat,
  input  logic [15:0]         quotient
);
  import smt_pkg::*;

  typedef enum logic [2:0] {LOAD, EXP_ISSUE, EXP_WAIT, DIV_ISSUE, DIV_WAIT, EMIT} state_t;
  state_t          state;
  logic [IdxW-1:0] idx;
  logic [CntW-1:0] n;
  logic            ovf;
  logic            acc, full;

  assign in_stall = (state != LOAD);
  assign acc = in_valid && !in_stall;
  assign full = (stat.count == CntW'(MaxLen));

  always_comb begin
    cmd = '0;
    cmd.idx = idx;
    cmd.load = acc && !full;
    cmd.exp_start = (state == EXP_ISSUE);
    cmd.div_start = (state == DIV_ISSUE);
    cmd.clear = (state == EMIT) && !out_stall && out_word.last_result;
  end

  // sequencer: load, exp sweep, one divide per result
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= LOAD; idx <= '0; n <= '0; ovf <= 1'b0; out_valid <= 1'b0;
    end else begin
      unique case (state)
        LOAD: begin
          if (acc) begin
            if (full) ovf <= 1'b1;
            if (in_word.last_element) begin
              n <= full ? stat.count : stat.count + 1'b1;
              idx <= '0;
              state <= EXP_ISSUE;
            end
          end
        end
        EXP_ISSUE: begin
          if (CntW'(idx) + 1'b1 == n) state <= EXP_WAIT;
          else idx <= idx + 1'b1;
        end
        EXP_WAIT: begin
          if (stat.exp_done && CntW'(idx) + 1'b1 == n) begin
            idx <= '0; state <= DIV_ISSUE;
          end
        end
        DIV_ISSUE: state <= DIV_WAIT;
        DIV_WAIT: begin
          if (stat.div_done) begin
            out_valid <= 1'b1;
            out_word.probability <= quotient;
            out_word.element_index <= 6'(idx);
            out_word.last_result <= (CntW'(idx) + 1'b1 == n);
            out_word.overflow <= ovf;
            state <= EMIT;
          end
        end
        EMIT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            if (out_word.last_result) begin
              ovf <= 1'b0; state <= LOAD;
            end else begin
              idx <= idx + 1'b1; state <= DIV_ISSUE;
            end
          end
        end
        default: state <= LOAD;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_out_emit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == EMIT) else $error("valid outside emit");
  a_no_in: assert property (@(posedge clk) disable iff (rst)
    state != LOAD |-> in_stall) else $error("input taken while busy");
  a_idx: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> CntW'(out_word.element_index) < n) else $error("index past count");
`endif

endmodule

// File: hw/rtl/softmax_with_temperature_unit.sv
// Softmax with temperature over vectors of up to 32 signed Q8.8 scores. Scores
// load one per cycle while the block is in its load state; the word marked last
// closes the vector, after which the block runs an exp sweep (one element a cycle
// through a four stage pipeline), then a bit-serial divide per result, with each
// result held through any output stall. Words past 32 are dropped and flag overflow.
// inv_temperature is the reciprocal temperature in Q8.8, reset 1.0.
module softmax_with_temperature_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  smt_pkg::in_word_t   in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output smt_pkg::out_word_t  out_word,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_data
);
  import smt_pkg::*;

  logic [15:0] inv_temperature;
  dp_cmd_t     cmd;
  dp_stat_t    stat;
  logic [15:0] quotient;

  // config register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) inv_temperature <= 16'd256;
    else if (cfg_valid && cfg_ready) inv_temperature <= cfg_data;
  end

  smt_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .in_word, .out_valid, .out_stall,
    .out_word, .cmd, .stat, .quotient
  );

  smt_datapath u_dp (
    .clk, .rst, .cmd, .in_score(in_word.score), .inv_temperature, .stat, .quotient
  );

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import smt_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_word;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [15:0] cfg_data = '0;

  softmax_with_temperature_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  logic signed [15:0] score_mem [MaxLen];
  logic [16:0] exp_mem [MaxLen];
  logic signed [15:0] peak_score;
  int unsigned score_count;
  logic dropped_flag;
  logic [15:0] inv_temp;

  in_word_t pending_words[$];
  out_word_t expected_probs[$];
  int errors = 0;
  int cycle_count = 0;
  logic hold_sender = 1'b0;
  logic in_taken = 1'b0;
  int burst_left = 0;
  int gap_left = 0;

  localparam logic [16:0] Pow2Tab [17] = '{65536, 62758, 60097, 57549, 55109, 52773,
    50535, 48393, 46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};

  function automatic logic [16:0] exp_of(logic signed [15:0] s);
    logic [63:0] d, y, n;
    logic [31:0] f, i, r, hi, lo, v;
    begin
      d = 64'(32'(int'(peak_score) - int'(s))) * 64'(inv_temp);
      y = (d * 64'd94548 + 64'd32768) >> 16;
      n = y >> 16;
      f = 32'(y & 64'hFFFF);
      i = f >> 12;
      r = f & 32'hFFF;
      hi = 32'(Pow2Tab[i]);
      lo = 32'(Pow2Tab[i + 1]);
      v = hi - (((hi - lo) * r + 32'd2048) >> 12);
      if (n >= 17) return 17'd0;
      return 17'(v >> n);
    end
  endfunction

  function automatic void vector_restart();
    peak_score = -16'sd32768;
    score_count = 0;
    dropped_flag = 1'b0;
  endfunction

  // predict the probabilities caused by one accepted word
  function automatic void predict_softmax(in_word_t w);
    logic [31:0] total, t;
    logic [63:0] p;
    out_word_t o;
    begin
      if (score_count < MaxLen) begin
        score_mem[score_count] = w.score;
        if (w.score > peak_score) peak_score = w.score;
        score_count++;
      end else begin
        dropped_flag = 1'b1;
      end
      if (!w.last_element) return;
      total = '0;
      for (int k = 0; k < score_count; k++) begin
        exp_mem[k] = exp_of(score_mem[k]);
        t = total + 32'(exp_mem[k]);
        total = (t > 32'd4194303) ? 32'd4194303 : t;
      end
      for (int k = 0; k < score_count; k++) begin
        p = '0;
        if (total != 0) begin
          p = (64'(exp_mem[k]) * 64'd65536 + 64'(total >> 1)) / 64'(total);
          if (p > 64'd65535) p = 64'd65535;
        end
        o.probability = p[15:0];
        o.element_index = 6'(k);
        o.last_result = (k + 1 == score_count);
        o.overflow = dropped_flag;
        expected_probs.push_back(o);
      end
      vector_restart();
    end
  endfunction

  // driver: bursts and gaps
  always @(negedge clk) begin
    if (!rst) begin
      if (in_taken) begin
        // accepted at the previous rising edge
        predict_softmax(in_word);
        pending_words.pop_front();
      end
      if (in_valid && !in_taken) begin
        // hold stalled word
      end else if (pending_words.size() == 0 || hold_sender) begin
        in_valid <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else begin
        in_valid <= 1'b1;
        in_word <= pending_words[0];
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(0, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        end
      end
      // receiver stall pattern
      case (cycle_count % 64 < 20 ? 0 : $urandom_range(0, 2))
        0: out_stall <= 1'b0;
        1: out_stall <= 1'b1;
        default: out_stall <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // the driver pops on acceptance, so sample the handshake at rising edge too
  always @(posedge clk) begin
    in_taken <= !rst && in_valid && !in_stall;
  end

  // monitor
  always @(posedge clk) begin
    out_word_t exp_w;
    cycle_count <= cycle_count + 1;
    if (!rst && out_valid && !out_stall) begin
      if (expected_probs.size() == 0) begin
        $error("unexpected word probability=%0d", out_word.probability);
        errors++;
      end else begin
        exp_w = expected_probs.pop_front();
        if (out_word.probability !== exp_w.probability) begin
          $error("probability exp %0d got %0d", exp_w.probability, out_word.probability);
          errors++;
        end
        if (out_word.element_index !== exp_w.element_index) begin
          $error("element_index exp %0d got %0d", exp_w.element_index,
                 out_word.element_index);
          errors++;
        end
        if (out_word.last_result !== exp_w.last_result) begin
          $error("last_result exp %0d got %0d", exp_w.last_result, out_word.last_result);
          errors++;
        end
        if (out_word.overflow !== exp_w.overflow) begin
          $error("overflow exp %0d got %0d", exp_w.overflow, out_word.overflow);
          errors++;
        end
      end
    end
  end

  // timeout
  always @(posedge clk) begin
    if (cycle_count > 900000) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic add_vector(int len, int mode);
    in_word_t w;
    for (int k = 0; k < len; k++) begin
      case (mode)
        0: w.score = 16'($urandom);
        1: w.score = 16'($urandom_range(0, 2047)) - 16'sd1024;
        default: w.score = ($urandom_range(0, 1)) ? 16'sh7FFF : 16'sh8000;
      endcase
      w.last_element = (k == len - 1);
      pending_words.push_back(w);
    end
  endtask

  task automatic drain();
    wait (pending_words.size() == 0 && !in_valid);
    wait (expected_probs.size() == 0);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_temp(logic [15:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    inv_temp = v;
  endtask

  task automatic random_phase(int words);
    int sent;
    sent = 0;
    while (sent < words) begin
      int len;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 36) : $urandom_range(1, 8);
      add_vector(len, $urandom_range(0, 3) == 0 ? 2 : $urandom_range(0, 1));
      sent += len;
    end
  endtask

  initial begin
    in_word_t w;
    inv_temp = 16'd256;
    vector_restart();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extremes, single element, full buffer with drops
    w.score = 16'sh7FFF; w.last_element = 1'b0; pending_words.push_back(w);
    w.score = 16'sh8000; w.last_element = 1'b0; pending_words.push_back(w);
    w.score = 16'sh0000; w.last_element = 1'b1; pending_words.push_back(w);
    w.score = 16'sh5555; w.last_element = 1'b1; pending_words.push_back(w);
    w.score = 16'shAAAA; w.last_element = 1'b0; pending_words.push_back(w);
    w.score = 16'shAA00; w.last_element = 1'b1; pending_words.push_back(w);
    drain();
    write_temp(16'd0);
    add_vector(3, 0);
    drain();
    write_temp(16'hFFFF);
    add_vector(4, 1);
    add_vector(34, 0);
    drain();
    // sender pauses until all results have come
    write_temp(16'd1);
    add_vector(5, 1);
    wait (pending_words.size() == 0 && !in_valid);
    hold_sender = 1'b1;
    add_vector(3, 1);
    wait (expected_probs.size() == 0);
    hold_sender = 1'b0;
    drain();

    write_temp(16'd256);
    random_phase(50);
    drain();
    write_temp(16'($urandom_range(1, 65535)));
    random_phase(45);
    drain();
    write_temp(16'd64);
    random_phase(45);
    drain();
    write_temp(16'hFFFF);
    random_phase(30);
    drain();

    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/smt_pkg.sv
hw/rtl/smt_datapath.sv
hw/rtl/smt_ctrl.sv
hw/rtl/softmax_with_temperature_unit.sv
dv/testbench.sv
